>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define AST_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

>>> sv/ffba_pkg.sv
package ffba_pkg;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_BADREL = 2'd2;

    localparam logic MODE_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        WR_RDATA,
        WR_USED,
        WR_SPLIT,
        WR_MERGE_CUR,
        WR_MERGE_PREV
    } wsel_t;

    typedef struct packed {
        logic       load_req;
        logic       rd_en;
        logic       wr_en;
        wsel_t      wr_sel;
        logic       lat_cur;
        logic       lat_prev;
        logic       lat_next;
        logic       use_next;
        logic       finish;
        logic [1:0] status;
        logic       grant;
    } dp_cmd_t;

    typedef struct packed {
        logic hit;
        logic rd_free;
        logic rel_mode;
        logic exact;
        logic big;
        logic prev_free;
        logic next_free;
    } dp_stat_t;

endpackage

>>> sv/ffba_dp.sv
module ffba_dp #(
    parameter int POOL_BYTES   = 16384,
    parameter int HEADER_BYTES = 24,
    parameter int MAX_BLOCKS   = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                mode,
    input  logic [14:0]                         request_bytes,
    input  logic [14:0]                         release_offset,
    input  ffba_pkg::dp_cmd_t                   cmd,
    input  logic [$clog2(MAX_BLOCKS)-1:0]       rd_addr,
    input  logic [$clog2(MAX_BLOCKS)-1:0]       wr_addr,
    output ffba_pkg::dp_stat_t                  st,
    output logic [1:0]                          status,
    output logic [14:0]                         payload_offset
);
    import ffba_pkg::*;

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int SW = $clog2(POOL_BYTES + 1);
    localparam int EW = 2 * SW + 1;
    localparam int XW = ((SW > 15) ? SW : 15) + 2;
    localparam logic [EW-1:0] E0_RESET =
        {SW'(0), SW'(POOL_BYTES - HEADER_BYTES), 1'b1};

    logic [EW-1:0] mem [MAX_BLOCKS];
    logic [EW-1:0] rdata_raw_reg;
    logic          rd_zero_reg;
    logic          e0_written_reg;
    logic [EW-1:0] rdata;
    logic [EW-1:0] wdata;

    logic [14:0]   req_reg;
    logic [14:0]   off_reg;
    logic          mode_reg;
    logic [SW-1:0] cur_start_reg;
    logic [SW-1:0] cur_size_reg;
    logic [SW-1:0] prev_start_reg;
    logic [SW-1:0] prev_size_reg;
    logic          prev_free_reg;
    logic [SW-1:0] next_size_reg;
    logic          next_free_reg;
    logic [1:0]    status_reg;
    logic [14:0]   poff_reg;

    logic [SW-1:0] r_start;
    logic [SW-1:0] r_size;
    logic          r_free;
    logic [XW-1:0] h_x;
    logic [XW-1:0] req_x;
    logic [XW-1:0] cur_size_x;
    logic [XW-1:0] sum_cur_x;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_raw_reg <= mem[rd_addr];
        end
    end

    // Entry zero reads as its reset value until first written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e0_written_reg <= 1'b0;
            rd_zero_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en && wr_addr == AW'(0))
            begin
                e0_written_reg <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rd_zero_reg <= (rd_addr == AW'(0)) && !e0_written_reg;
            end
        end
    end

    assign rdata = rd_zero_reg ? E0_RESET : rdata_raw_reg;
    assign r_start = rdata[EW-1 -: SW];
    assign r_size  = rdata[SW:1];
    assign r_free  = rdata[0];

    assign h_x        = XW'(HEADER_BYTES);
    assign req_x      = XW'(req_reg);
    assign cur_size_x = XW'(cur_size_reg);
    assign sum_cur_x  = cur_size_x + (cmd.use_next ? (XW'(next_size_reg) + h_x) : XW'(0));

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg  <= request_bytes;
            off_reg  <= release_offset;
            mode_reg <= mode;
        end
        if (cmd.lat_cur)
        begin
            cur_start_reg <= r_start;
            cur_size_reg  <= r_size;
        end
        if (cmd.lat_prev)
        begin
            prev_start_reg <= r_start;
            prev_size_reg  <= r_size;
            prev_free_reg  <= r_free;
        end
        if (cmd.lat_next)
        begin
            next_size_reg <= r_size;
            next_free_reg <= r_free;
        end
        if (cmd.finish)
        begin
            status_reg <= cmd.status;
            poff_reg   <= cmd.grant ? 15'(XW'(cur_start_reg) + h_x) : 15'd0;
        end
    end

    always_comb
    begin
        case (cmd.wr_sel)
            WR_RDATA:      wdata = rdata;
            WR_USED:       wdata = {cur_start_reg, SW'(req_reg), 1'b0};
            WR_SPLIT:      wdata = {SW'(XW'(cur_start_reg) + h_x + req_x),
                                    SW'(cur_size_x - req_x - h_x), 1'b1};
            WR_MERGE_CUR:  wdata = {cur_start_reg, SW'(sum_cur_x), 1'b1};
            WR_MERGE_PREV: wdata = {prev_start_reg,
                                    SW'(XW'(prev_size_reg) + h_x + sum_cur_x), 1'b1};
            default:       wdata = rdata;
        endcase
    end

    always_comb
    begin
        st.rel_mode  = (mode_reg == MODE_RELEASE);
        st.hit       = st.rel_mode ? ((XW'(r_start) + h_x) == XW'(off_reg))
                                   : (r_free && (XW'(r_size) >= req_x));
        st.rd_free   = r_free;
        st.exact     = (cur_size_x == req_x);
        st.big       = (cur_size_x > (req_x + h_x));
        st.prev_free = prev_free_reg;
        st.next_free = next_free_reg;
    end

    assign status         = status_reg;
    assign payload_offset = poff_reg;

endmodule

>>> sv/ffba_ctrl.sv
module ffba_ctrl #(
    parameter int MAX_BLOCKS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  ffba_pkg::dp_stat_t            st,
    output ffba_pkg::dp_cmd_t             cmd,
    output logic [$clog2(MAX_BLOCKS)-1:0] rd_addr,
    output logic [$clog2(MAX_BLOCKS)-1:0] wr_addr
);
    import ffba_pkg::*;

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_ADEC,
        S_SHUP,
        S_WSPLIT,
        S_WUSED,
        S_RNEXT,
        S_RWAIT,
        S_RMERGE,
        S_SHDN,
        S_DONE
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] iss_reg, iss_next;
    logic          rv_reg, rv_next;
    logic [AW-1:0] ridx_reg, ridx_next;
    logic [AW-1:0] fidx_reg, fidx_next;
    logic [1:0]    drop_reg, drop_next;
    logic [1:0]    code_reg, code_next;
    logic          grant_reg, grant_next;
    logic          has_next_reg, has_next_next;
    logic          out_valid_reg, out_valid_next;
    logic          pf;
    logic          nf;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        iss_next      = iss_reg;
        rv_next       = 1'b0;
        ridx_next     = ridx_reg;
        fidx_next     = fidx_reg;
        drop_next     = drop_reg;
        code_next     = code_reg;
        grant_next    = grant_reg;
        has_next_next = has_next_reg;
        cmd           = '0;
        cmd.wr_sel    = WR_RDATA;
        rd_addr       = '0;
        wr_addr       = '0;
        pf            = (fidx_reg != AW'(0)) && st.prev_free;
        nf            = has_next_reg && st.next_free;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    iss_next     = '0;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (iss_reg < count_reg)
                begin
                    cmd.rd_en = 1'b1;
                    rd_addr   = iss_reg[AW-1:0];
                    rv_next   = 1'b1;
                    ridx_next = iss_reg[AW-1:0];
                    iss_next  = iss_reg + CW'(1);
                end
                if (rv_reg)
                begin
                    if (st.hit)
                    begin
                        cmd.lat_cur = 1'b1;
                        fidx_next   = ridx_reg;
                        if (!st.rel_mode)
                        begin
                            state_next = S_ADEC;
                        end
                        else if (st.rd_free)
                        begin
                            code_next  = ST_BADREL;
                            grant_next = 1'b0;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_RNEXT;
                        end
                    end
                    else
                    begin
                        cmd.lat_prev = 1'b1;
                        if (CW'(ridx_reg) == count_reg - CW'(1))
                        begin
                            code_next  = st.rel_mode ? ST_BADREL : ST_NOFIT;
                            grant_next = 1'b0;
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_ADEC:
            begin
                if (st.exact)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_USED;
                    wr_addr    = fidx_reg;
                    code_next  = ST_OK;
                    grant_next = 1'b1;
                    state_next = S_DONE;
                end
                else if (st.big && count_reg != CW'(MAX_BLOCKS))
                begin
                    iss_next   = count_reg - CW'(1);
                    state_next = S_SHUP;
                end
                else
                begin
                    code_next  = ST_NOFIT;
                    grant_next = 1'b0;
                    state_next = S_DONE;
                end
            end
            S_SHUP:
            begin
                // open a slot after the split block, top entry first
                if (iss_reg > CW'(fidx_reg))
                begin
                    cmd.rd_en = 1'b1;
                    rd_addr   = iss_reg[AW-1:0];
                    rv_next   = 1'b1;
                    ridx_next = iss_reg[AW-1:0];
                    iss_next  = iss_reg - CW'(1);
                end
                if (rv_reg)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_RDATA;
                    wr_addr    = ridx_reg + AW'(1);
                end
                if (!(iss_reg > CW'(fidx_reg)) && !rv_reg)
                begin
                    state_next = S_WSPLIT;
                end
            end
            S_WSPLIT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_SPLIT;
                wr_addr    = fidx_reg + AW'(1);
                state_next = S_WUSED;
            end
            S_WUSED:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_USED;
                wr_addr    = fidx_reg;
                count_next = count_reg + CW'(1);
                code_next  = ST_OK;
                grant_next = 1'b1;
                state_next = S_DONE;
            end
            S_RNEXT:
            begin
                if (CW'(fidx_reg) + CW'(1) < count_reg)
                begin
                    cmd.rd_en     = 1'b1;
                    rd_addr       = fidx_reg + AW'(1);
                    has_next_next = 1'b1;
                    state_next    = S_RWAIT;
                end
                else
                begin
                    has_next_next = 1'b0;
                    state_next    = S_RMERGE;
                end
            end
            S_RWAIT:
            begin
                cmd.lat_next = 1'b1;
                state_next   = S_RMERGE;
            end
            S_RMERGE:
            begin
                cmd.use_next = nf;
                cmd.wr_en    = 1'b1;
                code_next    = ST_OK;
                grant_next   = 1'b0;
                if (pf)
                begin
                    cmd.wr_sel = WR_MERGE_PREV;
                    wr_addr    = fidx_reg - AW'(1);
                    drop_next  = nf ? 2'd2 : 2'd1;
                    iss_next   = CW'(fidx_reg) + (nf ? CW'(2) : CW'(1));
                    state_next = S_SHDN;
                end
                else if (nf)
                begin
                    cmd.wr_sel = WR_MERGE_CUR;
                    wr_addr    = fidx_reg;
                    drop_next  = 2'd1;
                    iss_next   = CW'(fidx_reg) + CW'(2);
                    state_next = S_SHDN;
                end
                else
                begin
                    cmd.wr_sel = WR_MERGE_CUR;
                    wr_addr    = fidx_reg;
                    state_next = S_DONE;
                end
            end
            S_SHDN:
            begin
                // close the gap left by merged entries
                if (iss_reg < count_reg)
                begin
                    cmd.rd_en = 1'b1;
                    rd_addr   = iss_reg[AW-1:0];
                    rv_next   = 1'b1;
                    ridx_next = iss_reg[AW-1:0];
                    iss_next  = iss_reg + CW'(1);
                end
                if (rv_reg)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_RDATA;
                    wr_addr    = ridx_reg - AW'(drop_reg);
                end
                if (!(iss_reg < count_reg) && !rv_reg)
                begin
                    count_next = count_reg - CW'(drop_reg);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    cmd.finish = 1'b1;
                    cmd.status = code_reg;
                    cmd.grant  = grant_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= CW'(1);
            iss_reg       <= '0;
            rv_reg        <= 1'b0;
            ridx_reg      <= '0;
            fidx_reg      <= '0;
            drop_reg      <= '0;
            code_reg      <= ST_OK;
            grant_reg     <= 1'b0;
            has_next_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            iss_reg       <= iss_next;
            rv_reg        <= rv_next;
            ridx_reg      <= ridx_next;
            fidx_reg      <= fidx_next;
            drop_reg      <= drop_next;
            code_reg      <= code_next;
            grant_reg     <= grant_next;
            has_next_reg  <= has_next_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;

endmodule

>>> sv/first_fit_block_allocator_top.sv
// First-fit pool allocator. The block table lives in a one-read, one-write memory and is
// walked one entry per cycle. An allocate stops at the first free block that fits; a
// split of that block moves every later entry up one slot. A release scans for the block,
// then fetches the next neighbor and merges; a merge moves the later entries down to
// close the gap. The next request is taken only once the allocator is back in idle.
// One request is in work at a time; a finished result waits in an output register, so
// the next request may be taken before it is drained. No clearing pass is needed after
// reset.
module first_fit_block_allocator_top #(
    parameter int POOL_BYTES   = 16384,
    parameter int HEADER_BYTES = 24,
    parameter int MAX_BLOCKS   = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        mode,
    input  logic [14:0] request_bytes,
    input  logic [14:0] release_offset,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [1:0]  status,
    output logic [14:0] payload_offset
);
    import ffba_pkg::*;

    localparam int AW = $clog2(MAX_BLOCKS);

    dp_cmd_t       cmd;
    dp_stat_t      st;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    ffba_ctrl #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .st        (st),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr)
    );

    ffba_dp #(
        .POOL_BYTES   (POOL_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_BLOCKS   (MAX_BLOCKS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .mode           (mode),
        .request_bytes  (request_bytes),
        .release_offset (release_offset),
        .cmd            (cmd),
        .rd_addr        (rd_addr),
        .wr_addr        (wr_addr),
        .st             (st),
        .status         (status),
        .payload_offset (payload_offset)
    );

endmodule

>>> sv/ffba_checker.sv
`include "assert_macros.svh"

module ffba_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_stall,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic [1:0]  status,
    input logic [14:0] payload_offset
);
    import ffba_pkg::*;

    `AST_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(status) && $stable(payload_offset))
    `AST_IMPLY(a_status_code, rsp_valid, status == ST_OK || status == ST_NOFIT || status == ST_BADREL)
    `AST_IMPLY(a_fail_zero, rsp_valid && status != ST_OK, payload_offset == 15'd0)
    `AST_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

endmodule

bind first_fit_block_allocator_top ffba_checker u_ffba_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .status         (status),
    .payload_offset (payload_offset)
);

>>> test/tb_first_fit_block_allocator_top.sv
module tb_first_fit_block_allocator_top;
    import ffba_pkg::*;

    localparam int POOL = 16384;
    localparam int HDR = 24;
    localparam int MAXB = 64;

    typedef struct {
        logic        mode;
        logic [14:0] req;
        logic [14:0] rel;
    } alloc_req_t;

    typedef struct {
        logic [1:0]  status;
        logic [14:0] offset;
    } alloc_rsp_t;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic        mode;
    logic [14:0] request_bytes;
    logic [14:0] release_offset;
    logic        rsp_valid;
    logic        rsp_stall;
    logic [1:0]  status;
    logic [14:0] payload_offset;

    alloc_req_t pending_q[$];
    alloc_rsp_t expected_q[$];
    // expected results are computed ahead in stimulus order
    alloc_rsp_t planned_q[$];
    int         used_offsets[$];
    int         mismatches;
    int         burst_left;
    int         gap_left;
    int         stall_phase;
    bit         hold_off;

    // shadow block table
    int pool_start[MAXB];
    int pool_size[MAXB];
    bit pool_free[MAXB];
    int pool_count;

    first_fit_block_allocator_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .mode           (mode),
        .request_bytes  (request_bytes),
        .release_offset (release_offset),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .payload_offset (payload_offset)
    );

    always #10 clk = ~clk;

    function automatic void table_remove(int idx);
        for (int k = idx; k + 1 < pool_count; k++)
        begin
            pool_start[k] = pool_start[k + 1];
            pool_size[k] = pool_size[k + 1];
            pool_free[k] = pool_free[k + 1];
        end
        pool_count--;
    endfunction

    function automatic alloc_rsp_t predict_allocation(alloc_req_t t);
        alloc_rsp_t r;
        int         i;
        int         req;
        r.status = ST_OK;
        r.offset = '0;
        if (t.mode != MODE_RELEASE)
        begin
            req = t.req;
            for (i = 0; i < pool_count; i++)
                if (pool_free[i] && pool_size[i] >= req)
                    break;
            if (i >= pool_count)
                r.status = ST_NOFIT;
            else if (pool_size[i] == req)
                pool_free[i] = 1'b0;
            else if (pool_size[i] > req + HDR)
            begin
                if (pool_count >= MAXB)
                    r.status = ST_NOFIT;
                else
                begin
                    for (int k = pool_count; k > i + 1; k--)
                    begin
                        pool_start[k] = pool_start[k - 1];
                        pool_size[k] = pool_size[k - 1];
                        pool_free[k] = pool_free[k - 1];
                    end
                    pool_start[i + 1] = pool_start[i] + HDR + req;
                    pool_size[i + 1] = pool_size[i] - req - HDR;
                    pool_free[i + 1] = 1'b1;
                    pool_count++;
                    pool_size[i] = req;
                    pool_free[i] = 1'b0;
                end
            end
            else
                r.status = ST_NOFIT;
            if (r.status == ST_OK)
                r.offset = 15'(pool_start[i] + HDR);
        end
        else
        begin
            for (i = 0; i < pool_count; i++)
                if (pool_start[i] + HDR == int'(t.rel))
                    break;
            if (i >= pool_count || pool_free[i])
                r.status = ST_BADREL;
            else
            begin
                pool_free[i] = 1'b1;
                if (i + 1 < pool_count && pool_free[i + 1])
                begin
                    pool_size[i] += pool_size[i + 1] + HDR;
                    table_remove(i + 1);
                end
                if (i > 0 && pool_free[i - 1])
                begin
                    pool_size[i - 1] += pool_size[i] + HDR;
                    table_remove(i);
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("tb: mismatch %s got %0d want %0d", what, got, want);
        mismatches++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            mode <= 1'b0;
            request_bytes <= '0;
            release_offset <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!(req_valid && req_stall))
        begin
            if (req_valid)
                void'(pending_q.pop_front());
            if (hold_off && expected_q.size() + pending_q.size() > 0)
                req_valid <= 1'b0;
            else if (pending_q.size() > 0 && gap_left == 0)
            begin
                alloc_req_t t;
                t = pending_q[0];
                req_valid <= 1'b1;
                mode <= t.mode;
                request_bytes <= t.req;
                release_offset <= t.rel;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
            begin
                req_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
        end
    end

    // monitor and response stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                expected_q.push_back(planned_q.pop_front());
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("unexpected result status", status, -1);
                else
                begin
                    alloc_rsp_t e;
                    e = expected_q.pop_front();
                    if (status !== e.status)
                        report_mismatch("status", status, e.status);
                    if (payload_offset !== e.offset)
                        report_mismatch("payload_offset", payload_offset, e.offset);
                end
            end
            stall_phase <= (stall_phase + 1) % 400;
            if (stall_phase < 100)
                rsp_stall <= 1'b0;
            else if (stall_phase < 250)
                rsp_stall <= ($urandom_range(0, 2) == 0);
            else
                rsp_stall <= ($urandom_range(0, 5) < 4);
        end
    end

    function automatic void plan_item(logic m, int req, int rel);
        alloc_req_t t;
        alloc_rsp_t r;
        t.mode = m;
        t.req = 15'(req);
        t.rel = 15'(rel);
        r = predict_allocation(t);
        pending_q.push_back(t);
        planned_q.push_back(r);
        if (m != MODE_RELEASE && r.status == ST_OK)
            used_offsets.push_back(r.offset);
        if (m == MODE_RELEASE && r.status == ST_OK)
            foreach (used_offsets[k])
                if (used_offsets[k] == rel)
                begin
                    used_offsets.delete(k);
                    break;
                end
    endfunction

    function automatic void plan_random();
        int pick;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                plan_item(1'b0, $urandom_range(0, 300), $urandom);
            else if (pick < 8)
                plan_item(1'b0, $urandom_range(0, 2000), $urandom);
            else
                plan_item(1'b0, $urandom & 16'h7fff, $urandom);
        end
        else if (sel < 90 && used_offsets.size() > 0)
        begin
            pick = $urandom_range(0, used_offsets.size() - 1);
            plan_item(1'b1, $urandom, used_offsets[pick]);
        end
        else if (sel < 95)
            plan_item(1'b1, $urandom, $urandom & 16'h7fff);
        else
            plan_item(1'b1, $urandom, HDR);
    endfunction

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        mismatches = 0;
        hold_off = 1'b0;
        pool_start[0] = 0;
        pool_size[0] = POOL - HDR;
        pool_free[0] = 1'b1;
        pool_count = 1;
        // directed
        plan_item(1'b1, 0, HDR);
        plan_item(1'b0, 0, 15'h7fff);
        plan_item(1'b0, 15'h7fff, 0);
        plan_item(1'b0, 100, 0);
        plan_item(1'b0, 100, 0);
        plan_item(1'b1, 0, 15'h7fff);
        plan_item(1'b1, 0, 48 + 100);
        plan_item(1'b1, 0, 48 + 100);
        plan_item(1'b1, 0, 48);
        plan_item(1'b0, 10, 0);
        plan_item(1'b0, 50, 0);
        plan_item(1'b0, 10, 0);
        plan_item(1'b1, 0, 48);
        plan_item(1'b0, 20, 0);
        plan_item(1'b0, 0, 0);
        plan_item(1'b0, POOL - HDR * 6 - 80, 0);
        plan_item(1'b0, 40, 0);
        plan_item(1'b0, 1, 0);
        for (int k = 0; k < 70; k++)
            plan_item(1'b0, $urandom_range(0, 8), 0);
        while (used_offsets.size() > 0)
            plan_item(1'b1, 0, used_offsets[0]);
        plan_item(1'b0, POOL - HDR, 0);
        plan_item(1'b1, 0, HDR);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (350)
            plan_random();
        wait (pending_q.size() == 0);
        @(posedge clk);
        hold_off <= 1'b1;
        wait (expected_q.size() == 0);
        @(posedge clk);
        hold_off <= 1'b0;
        repeat (350)
            plan_random();
        wait (pending_q.size() == 0 && expected_q.size() == 0);
        repeat (300) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("tb: failure");
        $finish;
    end
endmodule
